@@ hdl/lbr_pkg.sv @@
package lbr_pkg;

  // lfsr feedback taps, fallback seed, largest legal bound and reduction start
  localparam logic [7:0] LfsrTaps    = 8'hB8;
  localparam logic [7:0] SeedDefault = 8'd42;
  localparam logic [7:0] MaxDraw     = 8'd254;
  localparam logic [7:0] BoundStart  = 8'd255;

  // sequencer states
  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StDraw   = 4'b0010,
    StReduce = 4'b0100,
    StFinish = 4'b1000
  } state_e;

  // one galois step
  function automatic logic [7:0] lfsr_next(input logic [7:0] s);
    logic [7:0] n;
    n = {1'b0, s[7:1]};
    if (s[0]) begin
      n = n ^ LfsrTaps;
    end
    return n;
  endfunction

endpackage

@@ hdl/lfsr8_bounded_random_core.sv @@
// sequence: idle takes the word; each draw steps the lfsr in draw, then reduce
//   subtracts the range until r is below it, redrawing if the bound is short;
//   finish loads the output word; bad bounds skip to finish with no lfsr step
// throughput: one word at a time; reduce loops and output stalls set the rate
// reset: lfsr holds 42, sequencer idle, no output word pending
module lfsr8_bounded_random_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       seed_we_i,
  input  logic [7:0] seed_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] low_bound_i,
  input  logic [7:0] high_bound_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] value_o,
  output logic       bad_bounds_o
);
  import lbr_pkg::*;

  state_e     state_q, state_d;
  logic [7:0] lfsr_q;
  logic [7:0] lo_q;
  logic [7:0] range_q;
  logic [7:0] r_q;
  logic [7:0] bound_q;
  logic [7:0] res_val_q;
  logic       res_bad_q;
  logic       out_valid_q;
  logic [7:0] out_value_q;
  logic       out_bad_q;

  logic       in_accept;
  logic       in_bad;
  logic       out_free;
  logic [7:0] lfsr_step;
  logic [8:0] r_diff;
  logic       r_ge_range;
  logic       bound_ge_range;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign in_bad     = (low_bound_i >= high_bound_i) || (high_bound_i > MaxDraw);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign lfsr_step  = lfsr_next(lfsr_q);

  // shared subtract unit, borrow gives the compare
  assign r_diff         = {1'b0, r_q} - {1'b0, range_q};
  assign r_ge_range     = !r_diff[8];
  assign bound_ge_range = (bound_q >= range_q);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          state_d = in_bad ? StFinish : StDraw;
        end
      end
      StDraw: begin
        state_d = StReduce;
      end
      StReduce: begin
        if (!r_ge_range) begin
          state_d = bound_ge_range ? StFinish : StDraw;
        end
      end
      StFinish: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // lfsr, seed write reloads it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= SeedDefault;
    end else if (seed_we_i) begin
      lfsr_q <= (seed_wdata_i == 8'd0) ? SeedDefault : seed_wdata_i;
    end else if (state_q == StDraw) begin
      lfsr_q <= lfsr_step;
    end
  end

  // datapath of the reduction
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      lo_q      <= low_bound_i;
      range_q   <= high_bound_i - low_bound_i + 8'd1;
      res_val_q <= 8'd0;
      res_bad_q <= in_bad;
    end
    if (state_q == StDraw) begin
      r_q     <= lfsr_step - 8'd1;
      bound_q <= BoundStart;
    end
    if (state_q == StReduce) begin
      if (r_ge_range) begin
        r_q     <= r_diff[7:0];
        bound_q <= bound_q - range_q;
      end else if (bound_ge_range) begin
        res_val_q <= r_q + lo_q;
        res_bad_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == StFinish && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StFinish && out_free) begin
      out_value_q <= res_val_q;
      out_bad_q   <= res_bad_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = out_value_q;
  assign bad_bounds_o = out_bad_q;

`ifndef SYNTHESIS
  // lfsr never sticks at zero
  a_lfsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != 8'd0)
    else $error("lfsr reached zero");

  // the bound always stays above the remainder while reducing
  a_bound_above_r: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StReduce) |-> (bound_q > r_q))
    else $error("bound fell to remainder");

  // a valid request has a range of at least two
  a_range_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDraw || state_q == StReduce) |-> (range_q >= 8'd2))
    else $error("range below two in reduction");

  // bad bounds go straight to finish with the error flag
  a_bad_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_bad) |=> (state_q == StFinish && res_bad_q && res_val_q == 8'd0))
    else $error("bad bounds not flagged");
`endif

endmodule

@@ bench/tb_lfsr8_bounded_random_core.sv @@
`timescale 1ns / 1ps

module tb_lfsr8_bounded_random_core;
  import lbr_pkg::*;

  // one result word as the block returns it
  typedef struct packed {
    logic [7:0] value;
    logic       bad;
  } draw_t;

  // scoreboard with its own copy of the lfsr, predicts each draw on acceptance
  class draw_scoreboard;
    logic [7:0] lfsr;
    draw_t      expected_draws[$];
    int         requests;
    int         bad_requests;
    int         draws_checked;
    int         seed_loads;
    int         errors;

    function new();
      lfsr = SeedDefault;
    endfunction

    // a seed of zero would lock the lfsr, so the block falls back to the default
    function void load_seed(logic [7:0] seed);
      lfsr = (seed == 8'd0) ? SeedDefault : seed;
      seed_loads++;
    endfunction

    function int pending();
      return expected_draws.size();
    endfunction

    // rejection sampling: reduce by subtraction, reject the partial last interval
    function void note_request(logic [7:0] lo, logic [7:0] hi);
      draw_t      want;
      logic [8:0] span;
      logic [8:0] rem;
      logic [8:0] lim;
      int         tries;
      bit         done;
      want.value = 8'd0;
      want.bad   = 1'b0;
      requests++;
      if (lo >= hi || hi > MaxDraw) begin
        want.bad = 1'b1;
        bad_requests++;
      end else begin
        span = {1'b0, hi} - {1'b0, lo} + 9'd1;
        done = 1'b0;
        for (tries = 0; tries < 255 && !done; tries++) begin
          lfsr = {1'b0, lfsr[7:1]} ^ (lfsr[0] ? LfsrTaps : 8'h00);
          rem  = {1'b0, lfsr - 8'd1};
          lim  = {1'b0, BoundStart};
          while (rem >= span) begin
            rem = rem - span;
            lim = lim - span;
          end
          if (lim >= span) begin
            want.value = rem[7:0] + lo;
            done = 1'b1;
          end
        end
      end
      expected_draws.push_back(want);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // compare one returned word against the oldest prediction
    task check_draw(logic [7:0] value, logic bad);
      draw_t want;
      if (expected_draws.size() == 0) begin
        report($sformatf("unexpected word value=%0d bad=%0b", value, bad));
      end else begin
        want = expected_draws.pop_front();
        draws_checked++;
        if (value !== want.value) begin
          report($sformatf("value got %0d want %0d", value, want.value));
        end
        if (bad !== want.bad) begin
          report($sformatf("bad_bounds got %0b want %0b", bad, want.bad));
        end
      end
    endtask
  endclass

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       seed_we_i    = 1'b0;
  logic [7:0] seed_wdata_i = 8'd0;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  logic [7:0] low_bound_i  = 8'd0;
  logic [7:0] high_bound_i = 8'd0;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic [7:0] value_o;
  logic       bad_bounds_o;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_len    = 0;
  int hold_req    = 0;
  int hold_ack    = 0;
  int hold_cnt    = 0;

  draw_scoreboard sb;

  lfsr8_bounded_random_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_we_i    (seed_we_i),
    .seed_wdata_i (seed_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .low_bound_i  (low_bound_i),
    .high_bound_i (high_bound_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_o      (value_o),
    .bad_bounds_o (bad_bounds_o)
  );

  always #6 clk_i = ~clk_i;

  // watch both channels and the seed port
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (seed_we_i) begin
        sb.load_seed(seed_wdata_i);
      end
      if (in_valid_i && !in_stall_o) begin
        sb.note_request(low_bound_i, high_bound_i);
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_draw(value_o, bad_bounds_o);
      end
    end
  end

  // receiver stall, with an occasional long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_cnt    <= hold_len;
      out_stall_i <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt    <= hold_cnt - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // offer one word and wait for it to be taken; valid stays up afterwards unless an idle gap is drawn
  task automatic offer_request(logic [7:0] lo, logic [7:0] hi);
    int gap;
    in_valid_i   <= 1'b1;
    low_bound_i  <= lo;
    high_bound_i <= hi;
    do @(posedge clk_i); while (in_stall_o);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i   <= 1'b0;
      low_bound_i  <= 8'($urandom);
      high_bound_i <= 8'($urandom);
      gap = $urandom_range(6, 1);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drop valid and let every expected word come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_seed(logic [7:0] seed);
    seed_we_i    <= 1'b1;
    seed_wdata_i <= seed;
    @(posedge clk_i);
    seed_we_i    <= 1'b0;
    seed_wdata_i <= 8'($urandom);
    @(posedge clk_i);
  endtask

  // mostly legal bound pairs over a spread of range sizes, some illegal ones
  task automatic random_request();
    int         pick;
    int         span;
    logic [7:0] lo;
    logic [7:0] hi;
    pick = $urandom_range(99);
    if (pick < 4) begin
      hi = 8'($urandom_range(254));
      lo = 8'($urandom_range(255, hi));
    end else if (pick < 7) begin
      lo = 8'($urandom);
      hi = 8'd255;
    end else if (pick < 10) begin
      lo = 8'd255;
      hi = 8'($urandom);
    end else begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        span = $urandom_range(8, 2);
      end else if (pick < 70) begin
        span = $urandom_range(255, 2);
      end else if (pick < 85) begin
        span = $urandom_range(130, 64);
      end else begin
        span = $urandom_range(255, 200);
      end
      lo = 8'($urandom_range(255 - span));
      hi = lo + 8'(span - 1);
    end
    offer_request(lo, hi);
  endtask

  task automatic run_phase(int count, int tx_pct, int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    repeat (count) random_request();
    drain();
  endtask

  // directed corners: full range, narrow ranges, range of 128, every illegal shape
  task automatic directed_requests();
    offer_request(8'd0,   8'd254);
    offer_request(8'd0,   8'd1);
    offer_request(8'd253, 8'd254);
    offer_request(8'd100, 8'd227);
    offer_request(8'd0,   8'd127);
    offer_request(8'd10,  8'd11);
    offer_request(8'd0,   8'd253);
    offer_request(8'd1,   8'd254);
    offer_request(8'd254, 8'd254);
    offer_request(8'd5,   8'd3);
    offer_request(8'd0,   8'd0);
    offer_request(8'd0,   8'd255);
    offer_request(8'd255, 8'd255);
    offer_request(8'd255, 8'd0);
    offer_request(8'd127, 8'd128);
    offer_request(8'd85,  8'd170);
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset seed first, then a zero seed that must fall back to the default
    directed_requests();
    drain();
    write_seed(8'd0);
    directed_requests();
    drain();

    write_seed(8'd255);
    run_phase(400, 24, 88);
    write_seed(8'd1);
    run_phase(400, 88, 24);
    write_seed(8'($urandom_range(254, 2)));
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    repeat (150) random_request();

    // long output hold-off while words keep coming, so the input backs up
    hold_len <= 300;
    hold_req <= hold_req + 1;
    repeat (12) random_request();

    // sender waits for everything outstanding, then carries on
    drain();
    write_seed(8'd128);
    run_phase(230, 0, 0);

    repeat (300) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d predicted words never came back", sb.pending()));
    end

    $display("covered %0d requests (%0d with illegal bounds), %0d seed loads,",
             sb.requests, sb.bad_requests, sb.seed_loads);
    $display("three idle mixes and one long output hold-off; %0d words checked",
             sb.draws_checked);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #48000000;
    $display("timeout with %0d words outstanding", sb.pending());
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ lfsr8_bounded_random_core.f @@
hdl/lbr_pkg.sv
hdl/lfsr8_bounded_random_core.sv
bench/tb_lfsr8_bounded_random_core.sv
